// ===== src/wmad_pkg.sv =====
// ---------------------------------------------------------------------------
// wmad_pkg
// shared constants, codes and transaction types of the window minimum
// absolute difference unit
// ---------------------------------------------------------------------------
`default_nettype none

package wmad_pkg;

  // defaults of the top-level parameters
  localparam int MAX_WIDTH_DEF   = 1024;
  localparam int SAMPLE_BITS_DEF = 32;
  localparam int RADIUS_DEF      = 3;

  // fixed field widths
  localparam int IN_BITS       = 32;
  localparam int DIFF_BITS     = 32;
  localparam int ROW_BITS      = 12;
  localparam int COL_BITS      = 10;
  localparam int CFG_W_BITS    = 11;
  localparam int CFG_H_BITS    = 13;
  localparam int CFG_IDX_BITS  = 1;
  localparam int CFG_DATA_BITS = 13;
  localparam int OUT_DATA_BITS = 56;
  localparam int OUT_PAD_BITS  = OUT_DATA_BITS - (DIFF_BITS + 1 + ROW_BITS + COL_BITS);

  localparam int MAX_HEIGHT = 4096;

  localparam logic [CFG_W_BITS-1:0] WIDTH_RESET  = 11'd640;
  localparam logic [CFG_H_BITS-1:0] HEIGHT_RESET = 13'd480;

  // result queue and compare tree sizing
  localparam int RES_FIFO_DEPTH = 8;
  localparam int TREE_LEAVES    = 64;

  typedef enum logic {
    CMD_PIXEL = 1'b0,
    CMD_FLUSH = 1'b1
  } cmd_e;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } reg_idx_e;

  // per-item side information travelling with the window data
  typedef struct packed {
    logic                emit;
    logic [ROW_BITS-1:0] row;
    logic [COL_BITS-1:0] col;
    logic                last;
  } meta_t;

  typedef struct packed {
    logic [DIFF_BITS-1:0] min_diff;
    logic                 none_found;
    logic [ROW_BITS-1:0]  row;
    logic [COL_BITS-1:0]  col;
    logic                 last;
  } res_t;

endpackage

`default_nettype wire

// ===== src/window_min_abs_difference_unit.sv =====
// ---------------------------------------------------------------------------
// window_min_abs_difference_unit
// windowed minimum absolute difference over a raster stream of signed samples
// ---------------------------------------------------------------------------
// Takes one item per clock. Each pixel sample is compared with every in-frame
// pixel of its (2*RADIUS+1)^2 window, and the smallest absolute difference
// (saturated to 32 bits) is returned with the pixel's row and column; if no
// neighbour lies in the frame none_found is set and min_diff is all ones. A
// result for a pixel is released by the item that arrives RADIUS rows and
// RADIUS pixels later, so flush items (tuser high) after the last pixel drain
// the tail of the frame; a flush while pixels are still expected is taken and
// ignored, and a pixel after the last one is treated as a flush. tlast marks
// the final pixel's result, after which the raster counters restart. The
// line store is a single MAX_WIDTH-deep memory whose word holds the previous
// 2*RADIUS rows of a column; every advancing item does one read and, in the
// cycle after, one write-back of it. A result is registered in the line
// store and along the compare tree before the 8-entry output queue; input
// ready drops only when the queue and results in flight would exceed its
// room. The memory needs no clearing pass after reset.
// ---------------------------------------------------------------------------
`default_nettype none

module window_min_abs_difference_unit import wmad_pkg::*; #(
  parameter int MAX_WIDTH   = MAX_WIDTH_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int RADIUS      = RADIUS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // input stream
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  input  logic [IN_BITS-1:0]       s_axis_tdata,   // [31:0] sample
  input  logic                     s_axis_tuser,   // [0] cmd
  // result stream
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  output logic [OUT_DATA_BITS-1:0] m_axis_tdata,   // min_diff, none_found, out_row, out_col
  output logic                     m_axis_tlast,   // frame_last
  // configuration write channel
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index_i,
  input  logic [CFG_DATA_BITS-1:0] cfg_data_i
);

  localparam int SW  = (SAMPLE_BITS > IN_BITS) ? IN_BITS : SAMPLE_BITS;
  localparam int N   = 2 * RADIUS + 1;
  localparam int AW  = $clog2(MAX_WIDTH);
  localparam int WW  = $clog2(MAX_WIDTH + 1);
  localparam int HW  = CFG_H_BITS;
  localparam int LW  = $clog2(RADIUS * MAX_WIDTH + RADIUS + 1);
  localparam int FCW = $clog2(RES_FIFO_DEPTH + 1);

  // configuration registers
  logic [CFG_W_BITS-1:0] width_q;
  logic [CFG_H_BITS-1:0] height_q;

  // clamped frame geometry and result lag
  logic [WW-1:0] eff_w;
  logic [HW-1:0] eff_h;
  logic [LW-1:0] lag;

  // raster position of the next item, lag counter, position of next result
  logic [AW-1:0]       pcol_q, pcol_d;
  logic [HW-1:0]       prow_q, prow_d;
  logic [LW-1:0]       cnt_q, cnt_d;
  logic [AW-1:0]       ecol_q, ecol_d;
  logic [ROW_BITS-1:0] erow_q, erow_d;

  logic acc;
  logic is_flush;
  logic pixel_phase;
  logic adv;
  logic emit_now;
  logic pcol_last;
  logic ecol_last;
  logic erow_last;
  logic frame_end;

  logic [N-1:0] rmask, cmask;
  meta_t        meta;

  // memory stage side data
  meta_t        s1_meta_q;
  logic [N-1:0] s1_rmask_q, s1_cmask_q;

  logic                 col_valid;
  logic [N-1:0][SW-1:0] col;
  logic                 res_valid;
  res_t                 res;
  res_t                 fifo_out;
  logic [FCW-1:0]       fifo_cnt;
  logic [FCW-1:0]       inflight_q;
  logic                 out_pop;

  // -------------------------------------------------------------------------
  // configuration
  // -------------------------------------------------------------------------
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RESET;
      height_q <= HEIGHT_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (reg_idx_e'(cfg_index_i))
        REG_FRAME_WIDTH:  width_q  <= cfg_data_i[CFG_W_BITS-1:0];
        REG_FRAME_HEIGHT: height_q <= cfg_data_i[CFG_H_BITS-1:0];
      endcase
    end
  end

  // zero acts as one, oversize values clamp to the largest frame
  always_comb begin
    if (width_q == '0) begin
      eff_w = WW'(1);
    end else if (int'(width_q) > MAX_WIDTH) begin
      eff_w = WW'(MAX_WIDTH);
    end else begin
      eff_w = WW'(width_q);
    end
    if (height_q == '0) begin
      eff_h = HW'(1);
    end else if (int'(height_q) > MAX_HEIGHT) begin
      eff_h = HW'(MAX_HEIGHT);
    end else begin
      eff_h = height_q;
    end
  end

  assign lag = LW'(RADIUS * int'(eff_w) + RADIUS);

  // -------------------------------------------------------------------------
  // item classification
  // -------------------------------------------------------------------------
  assign acc         = s_axis_tvalid && s_axis_tready;
  assign is_flush    = (cmd_e'(s_axis_tuser) == CMD_FLUSH);
  assign pixel_phase = (prow_q < eff_h);
  // a flush while pixels are still expected changes nothing
  assign adv         = acc && !(pixel_phase && is_flush);
  assign emit_now    = adv && !(cnt_q < lag);
  assign pcol_last   = (WW'(pcol_q) == eff_w - WW'(1));
  assign ecol_last   = (WW'(ecol_q) == eff_w - WW'(1));
  assign erow_last   = (HW'(erow_q) == eff_h - HW'(1));
  assign frame_end   = emit_now && ecol_last && erow_last;

  always_comb begin
    pcol_d = pcol_q;
    prow_d = prow_q;
    cnt_d  = cnt_q;
    ecol_d = ecol_q;
    erow_d = erow_q;
    if (adv) begin
      if (frame_end) begin
        pcol_d = '0;
        prow_d = '0;
        cnt_d  = '0;
        ecol_d = '0;
        erow_d = '0;
      end else begin
        if (pcol_last) begin
          pcol_d = '0;
          // row count stops at the frame height during the drain
          if (pixel_phase) begin
            prow_d = prow_q + HW'(1);
          end
        end else begin
          pcol_d = pcol_q + AW'(1);
        end
        if (cnt_q < lag) begin
          cnt_d = cnt_q + LW'(1);
        end
        if (emit_now) begin
          if (ecol_last) begin
            ecol_d = '0;
            erow_d = erow_q + ROW_BITS'(1);
          end else begin
            ecol_d = ecol_q + AW'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pcol_q <= '0;
      prow_q <= '0;
      cnt_q  <= '0;
      ecol_q <= '0;
      erow_q <= '0;
    end else begin
      pcol_q <= pcol_d;
      prow_q <= prow_d;
      cnt_q  <= cnt_d;
      ecol_q <= ecol_d;
      erow_q <= erow_d;
    end
  end

  // in-frame masks of window rows and columns around the result pixel
  always_comb begin
    for (int j = 0; j < N; j++) begin
      rmask[j] = (int'(erow_q) + j - RADIUS >= 0) &&
                 (int'(erow_q) + j - RADIUS < int'(eff_h));
      cmask[j] = (int'(ecol_q) + j - RADIUS >= 0) &&
                 (int'(ecol_q) + j - RADIUS < int'(eff_w));
    end
  end

  always_comb begin
    meta.emit = emit_now;
    meta.row  = erow_q;
    meta.col  = COL_BITS'(ecol_q);
    meta.last = frame_end;
  end

  // side data is registered alongside the line store read
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_meta_q  <= meta;
      s1_rmask_q <= rmask;
      s1_cmask_q <= cmask;
    end
  end

  // -------------------------------------------------------------------------
  // datapath
  // -------------------------------------------------------------------------
  wmad_line_store #(
    .MAX_WIDTH (MAX_WIDTH),
    .SW        (SW),
    .RADIUS    (RADIUS)
  ) u_line_store (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .wr_en_i     (adv),
    .addr_i      (pcol_q),
    .sample_i    (s_axis_tdata[SW-1:0]),
    .col_valid_o (col_valid),
    .col_o       (col)
  );

  wmad_min_tree #(
    .SW     (SW),
    .RADIUS (RADIUS)
  ) u_min_tree (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (col_valid),
    .col_i       (col),
    .meta_i      (s1_meta_q),
    .rmask_i     (s1_rmask_q),
    .cmask_i     (s1_cmask_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  wmad_result_fifo #(
    .DEPTH (RES_FIFO_DEPTH)
  ) u_result_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_valid),
    .data_i  (res),
    .pop_i   (out_pop),
    .valid_o (m_axis_tvalid),
    .data_o  (fifo_out),
    .count_o (fifo_cnt)
  );

  // results in the pipeline hold a queue slot in advance
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= '0;
    end else if (emit_now && !res_valid) begin
      inflight_q <= inflight_q + FCW'(1);
    end else if (res_valid && !emit_now) begin
      inflight_q <= inflight_q - FCW'(1);
    end
  end

  assign s_axis_tready = ({1'b0, fifo_cnt} + {1'b0, inflight_q}) < (FCW + 1)'(RES_FIFO_DEPTH);

  assign out_pop      = m_axis_tvalid && m_axis_tready;
  assign m_axis_tdata = {{OUT_PAD_BITS{1'b0}}, fifo_out.col, fifo_out.row,
                         fifo_out.none_found, fifo_out.min_diff};
  assign m_axis_tlast = fifo_out.last;

  // -------------------------------------------------------------------------
  // assertions
  // -------------------------------------------------------------------------
  a_credit_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, fifo_cnt} + {1'b0, inflight_q}) <= (FCW + 1)'(RES_FIFO_DEPTH))
    else $error("result credits exceed queue room");

  a_push_room : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> (fifo_cnt < FCW'(RES_FIFO_DEPTH)))
    else $error("result pushed into a full queue");

  a_frame_restart : assert property (@(posedge clk_i) disable iff (!rst_ni)
    frame_end |=> (pcol_q == '0 && prow_q == '0 && cnt_q == '0 &&
                   ecol_q == '0 && erow_q == '0))
    else $error("raster counters not cleared after the last result");

  a_flush_ignored : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && is_flush && pixel_phase) |=> ($stable(pcol_q) && $stable(cnt_q)))
    else $error("flush during the pixel phase moved the raster position");

endmodule

`default_nettype wire

// ===== src/wmad_line_store.sv =====
// ---------------------------------------------------------------------------
// wmad_line_store
// line buffer memory: one word per column holding the previous 2*RADIUS rows,
// read-modify-write per advancing item with forwarding for back-to-back hits
// ---------------------------------------------------------------------------
`default_nettype none

module wmad_line_store import wmad_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF,
  parameter int SW        = IN_BITS,
  parameter int RADIUS    = RADIUS_DEF,
  localparam int AW       = $clog2(MAX_WIDTH)
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     wr_en_i,
  input  logic [AW-1:0]            addr_i,
  input  logic [SW-1:0]            sample_i,
  output logic                     col_valid_o,
  output logic [2*RADIUS:0][SW-1:0] col_o     // index 0 is the oldest row
);

  localparam int LINES     = 2 * RADIUS;
  localparam int WORD_BITS = LINES * SW;

  logic [WORD_BITS-1:0] mem_q [MAX_WIDTH];
  logic [WORD_BITS-1:0] rd_q;
  logic [WORD_BITS-1:0] last_wr_q;
  logic [WORD_BITS-1:0] word;
  logic [WORD_BITS-1:0] new_word;
  logic [AW-1:0]        addr_q;
  logic [SW-1:0]        x_q;
  logic                 v_q;
  logic                 fwd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      rd_q   <= mem_q[addr_i];
      addr_q <= addr_i;
      x_q    <= sample_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (v_q) begin
      mem_q[addr_q] <= new_word;
      last_wr_q     <= new_word;
    end
  end

  // the write of the word in flight lands on the same edge as the read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q   <= 1'b0;
      fwd_q <= 1'b0;
    end else begin
      v_q   <= wr_en_i;
      fwd_q <= wr_en_i && v_q && (addr_q == addr_i);
    end
  end

  assign word     = fwd_q ? last_wr_q : rd_q;
  assign new_word = {word[WORD_BITS-SW-1:0], x_q};

  always_comb begin
    for (int i = 0; i < LINES; i++) begin
      col_o[i] = word[(LINES-1-i)*SW +: SW];
    end
    col_o[LINES] = x_q;
  end

  assign col_valid_o = v_q;

endmodule

`default_nettype wire

// ===== src/wmad_min_tree.sv =====
// ---------------------------------------------------------------------------
// wmad_min_tree
// window register array, masked absolute differences to the centre and a
// registered minimum tree
// ---------------------------------------------------------------------------
`default_nettype none

module wmad_min_tree import wmad_pkg::*; #(
  parameter int SW     = IN_BITS,
  parameter int RADIUS = RADIUS_DEF,
  localparam int N     = 2 * RADIUS + 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  logic [N-1:0][SW-1:0] col_i,
  input  meta_t                meta_i,
  input  logic [N-1:0]         rmask_i,
  input  logic [N-1:0]         cmask_i,
  output logic                 res_valid_o,
  output res_t                 res_o
);

  localparam int L1 = TREE_LEAVES / 4;
  localparam int L2 = L1 / 4;

  function automatic logic [DIFF_BITS-1:0] min4(input logic [3:0][DIFF_BITS-1:0] v);
    logic [DIFF_BITS-1:0] a;
    logic [DIFF_BITS-1:0] b;
    a = (v[1] < v[0]) ? v[1] : v[0];
    b = (v[3] < v[2]) ? v[3] : v[2];
    return (b < a) ? b : a;
  endfunction

  // [row][slot], slot 0 is the newest column
  logic [N-1:0][N-1:0][SW-1:0] win_q;

  logic                 v2_q, v3_q, v4_q, v5_q;
  meta_t                meta2_q, meta3_q, meta4_q, meta5_q;
  logic [N-1:0]         rm2_q, cm2_q;
  logic                 found3_q, found4_q, found5_q;

  logic [TREE_LEAVES-1:0][DIFF_BITS-1:0] leaf;
  logic                                  found;
  logic [TREE_LEAVES-1:0][DIFF_BITS-1:0] lf_q;
  logic [L1-1:0][DIFF_BITS-1:0]          lv1_q;
  logic [L2-1:0][DIFF_BITS-1:0]          lv2_q;
  res_t                                  res_q;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      for (int i = 0; i < N; i++) begin
        win_q[i][0] <= col_i[i];
        for (int k = 1; k < N; k++) begin
          win_q[i][k] <= win_q[i][k-1];
        end
      end
      meta2_q <= meta_i;
      rm2_q   <= rmask_i;
      cm2_q   <= cmask_i;
    end
  end

  // differences to the centre, out-of-frame lanes forced to all ones
  always_comb begin
    logic signed [SW:0] dv;
    logic [SW:0]        av;
    logic [32:0]        aw;
    leaf  = '1;
    found = 1'b0;
    for (int i = 0; i < N; i++) begin
      for (int k = 0; k < N; k++) begin
        dv = $signed({win_q[RADIUS][RADIUS][SW-1], win_q[RADIUS][RADIUS]})
           - $signed({win_q[i][k][SW-1], win_q[i][k]});
        av = dv[SW] ? $unsigned(-dv) : $unsigned(dv);
        aw = 33'(av);
        if (!(i == RADIUS && k == RADIUS) && rm2_q[i] && cm2_q[N-1-k]) begin
          found            = 1'b1;
          leaf[i * N + k]  = aw[32] ? '1 : aw[DIFF_BITS-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    lf_q     <= leaf;
    found3_q <= found;
    meta3_q  <= meta2_q;
    for (int j = 0; j < L1; j++) begin
      lv1_q[j] <= min4(lf_q[4*j +: 4]);
    end
    found4_q <= found3_q;
    meta4_q  <= meta3_q;
    for (int j = 0; j < L2; j++) begin
      lv2_q[j] <= min4(lv1_q[4*j +: 4]);
    end
    found5_q <= found4_q;
    meta5_q  <= meta4_q;
    res_q.min_diff   <= min4(lv2_q);
    res_q.none_found <= !found5_q;
    res_q.row        <= meta5_q.row;
    res_q.col        <= meta5_q.col;
    res_q.last       <= meta5_q.last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      v4_q        <= 1'b0;
      v5_q        <= 1'b0;
      res_valid_o <= 1'b0;
    end else begin
      v2_q        <= push_i && meta_i.emit;
      v3_q        <= v2_q;
      v4_q        <= v3_q;
      v5_q        <= v4_q;
      res_valid_o <= v5_q;
    end
  end

  assign res_o = res_q;

endmodule

`default_nettype wire

// ===== src/wmad_result_fifo.sv =====
// ---------------------------------------------------------------------------
// wmad_result_fifo
// small result queue between the compare pipeline and the output stream
// ---------------------------------------------------------------------------
`default_nettype none

module wmad_result_fifo import wmad_pkg::*; #(
  parameter int DEPTH = RES_FIFO_DEPTH,
  localparam int PW   = $clog2(DEPTH),
  localparam int CW   = $clog2(DEPTH + 1)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  res_t          data_i,
  input  logic          pop_i,
  output logic          valid_o,
  output res_t          data_o,
  output logic [CW-1:0] count_o
);

  res_t          buf_q [DEPTH];
  logic [PW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CW-1:0] count_q;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      buf_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CW'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CW'(1);
      end
    end
  end

  assign valid_o = (count_q != '0);
  assign data_o  = buf_q[rd_ptr_q];
  assign count_o = count_q;

endmodule

`default_nettype wire

// ===== bench/wmad_checker.sv =====
// ---------------------------------------------------------------------------
// window_min_abs_difference_checker
// watches the sample, result and register channels of the window minimum
// absolute difference unit, tracks the raster state and checks each result
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module window_min_abs_difference_checker import wmad_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  input  logic                     in_ready_i,
  input  logic [IN_BITS-1:0]       in_data_i,    // [31:0] sample
  input  logic                     in_user_i,    // [0] cmd
  input  logic                     res_valid_i,
  input  logic                     res_ready_i,
  input  logic [OUT_DATA_BITS-1:0] res_data_i,   // min_diff, none_found, out_row, out_col
  input  logic                     res_last_i,   // frame_last
  input  logic                     cfg_valid_i,
  input  logic                     cfg_ready_i,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index_i,
  input  logic [CFG_DATA_BITS-1:0] cfg_data_i,
  output int                       mismatches_o,
  output int                       outstanding_o
);

  localparam int RING_DEPTH = (2 * RADIUS_DEF + 2) * MAX_WIDTH_DEF;

  logic [CFG_W_BITS-1:0]      row_len;
  logic [CFG_H_BITS-1:0]      frame_rows;
  logic signed [IN_BITS-1:0]  sample_ring [RING_DEPTH];
  int unsigned                raster_row;
  int unsigned                raster_col;
  int unsigned                emitted;
  res_t                       pending_minima [$];

  function automatic int unsigned eff_width();
    int unsigned w;
    w = 32'(row_len);
    if (w == 0) w = 1;
    if (w > MAX_WIDTH_DEF) w = MAX_WIDTH_DEF;
    return w;
  endfunction

  function automatic int unsigned eff_height();
    int unsigned h;
    h = 32'(frame_rows);
    if (h == 0) h = 1;
    if (h > MAX_HEIGHT) h = MAX_HEIGHT;
    return h;
  endfunction

  // advances the raster by one item unless it is a swallowed flush; returns 1 when the item releases a result
  function automatic bit predict_min(input cmd_e cmd, input logic [IN_BITS-1:0] smp,
                                     output res_t res);
    int unsigned w, h, total, lag, pos, e;
    int r, c, rr, cc;
    longint centre, d;
    longint best;
    bit found, hit;
    w     = eff_width();
    h     = eff_height();
    total = w * h;
    lag   = RADIUS_DEF * w + RADIUS_DEF;
    pos   = raster_row * w + raster_col;
    hit   = 1'b0;
    res   = '0;
    // flush while pixels are still due: swallowed
    if (pos < total && cmd == CMD_FLUSH) return 1'b0;
    if (pos < total) sample_ring[pos % RING_DEPTH] = smp;
    if (pos >= lag) begin
      e      = emitted;
      r      = int'(e / w);
      c      = int'(e % w);
      centre = longint'(sample_ring[e % RING_DEPTH]);
      best   = 64'hFFFF_FFFF;
      found  = 1'b0;
      for (int dr = -RADIUS_DEF; dr <= RADIUS_DEF; dr++) begin
        for (int dc = -RADIUS_DEF; dc <= RADIUS_DEF; dc++) begin
          rr = r + dr;
          cc = c + dc;
          if (!(dr == 0 && dc == 0) && rr >= 0 && cc >= 0 && rr < int'(h) && cc < int'(w)) begin
            d = centre - longint'(sample_ring[(rr * w + cc) % RING_DEPTH]);
            if (d < 0) d = -d;
            if (d > 64'hFFFF_FFFF) d = 64'hFFFF_FFFF;
            found = 1'b1;
            if (d < best) best = d;
          end
        end
      end
      res.min_diff   = best[DIFF_BITS-1:0];
      res.none_found = !found;
      res.row        = r[ROW_BITS-1:0];
      res.col        = c[COL_BITS-1:0];
      emitted        = e + 1;
      res.last       = (emitted >= total);
      hit            = 1'b1;
      if (emitted >= total) begin
        raster_row = 0;
        raster_col = 0;
        emitted    = 0;
        return 1'b1;
      end
    end
    raster_col++;
    if (raster_col >= w) begin
      raster_col = 0;
      raster_row++;
    end
    return hit;
  endfunction

  function automatic void check_field(input string field, input longint unsigned want,
                                      input longint unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      mismatches_o++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    res_t want, got;
    if (!rst_ni) begin
      row_len    = WIDTH_RESET;
      frame_rows = HEIGHT_RESET;
      raster_row = 0;
      raster_col = 0;
      emitted    = 0;
      for (int i = 0; i < RING_DEPTH; i++) sample_ring[i] = '0;
      pending_minima.delete();
      mismatches_o  = 0;
      outstanding_o = 0;
    end else begin
      if (res_valid_i && res_ready_i) begin
        got.min_diff   = res_data_i[DIFF_BITS-1:0];
        got.none_found = res_data_i[DIFF_BITS];
        got.row        = res_data_i[DIFF_BITS+1 +: ROW_BITS];
        got.col        = res_data_i[DIFF_BITS+1+ROW_BITS +: COL_BITS];
        got.last       = res_last_i;
        if (pending_minima.size() == 0) begin
          $error("unexpected result transaction at row %0d col %0d", got.row, got.col);
          mismatches_o++;
        end else begin
          want = pending_minima.pop_front();
          check_field("min_diff", want.min_diff, got.min_diff);
          check_field("none_found", want.none_found, got.none_found);
          check_field("out_row", want.row, got.row);
          check_field("out_col", want.col, got.col);
          check_field("frame_last", want.last, got.last);
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        if (reg_idx_e'(cfg_index_i) == REG_FRAME_WIDTH) row_len = cfg_data_i[CFG_W_BITS-1:0];
        else frame_rows = cfg_data_i[CFG_H_BITS-1:0];
      end
      if (in_valid_i && in_ready_i) begin
        if (predict_min(cmd_e'(in_user_i), in_data_i, want)) begin
          pending_minima = {pending_minima, want};
        end
      end
      outstanding_o = pending_minima.size();
    end
  end

endmodule

// ===== bench/tb_window_min_abs_difference_unit.sv =====
// ---------------------------------------------------------------------------
// tb_window_min_abs_difference_unit
// self-checking regression of the window minimum absolute difference unit
// ---------------------------------------------------------------------------
// Streams whole frames of signed samples through the unit under a range of
// frame sizes, including zero register values and unused high bits of the
// width register. A short set of hand-picked frames comes first (lone pixel,
// full-scale differences, swallowed and dropped items), then random frames
// with bursty input and a stalling result side. The checker beside the unit
// predicts every result and counts mismatches.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_window_min_abs_difference_unit;
  import wmad_pkg::*;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     s_axis_tvalid = 1'b0;
  logic                     s_axis_tready;
  logic [IN_BITS-1:0]       s_axis_tdata = '0;     // [31:0] sample
  logic                     s_axis_tuser = 1'b0;   // [0] cmd
  logic                     m_axis_tvalid;
  logic                     m_axis_tready = 1'b0;
  logic [OUT_DATA_BITS-1:0] m_axis_tdata;          // min_diff, none_found, out_row, out_col
  logic                     m_axis_tlast;          // frame_last
  logic                     cfg_valid_i = 1'b0;
  logic                     cfg_ready_o;
  logic [CFG_IDX_BITS-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data_i = '0;

  int                       fail_count;
  int                       outstanding;

  // sender burst bookkeeping and the frame size the unit is working to
  int unsigned              burst_left = 0;
  int unsigned              cur_w = 640;
  int unsigned              cur_h = 480;
  int unsigned              items_done = 0;
  logic [IN_BITS-1:0]       sample_base = '0;

  // receiver stall pattern
  int unsigned              rx_mode = 0;
  int unsigned              rx_span = 0;
  int unsigned              rx_phase = 0;

  window_min_abs_difference_unit DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  window_min_abs_difference_checker checker_inst (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_i    (s_axis_tready),
    .in_data_i     (s_axis_tdata),
    .in_user_i     (s_axis_tuser),
    .res_valid_i   (m_axis_tvalid),
    .res_ready_i   (m_axis_tready),
    .res_data_i    (m_axis_tdata),
    .res_last_i    (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_i   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .mismatches_o  (fail_count),
    .outstanding_o (outstanding)
  );

  // 12 ns clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // result side: every so often pick a new stall behaviour and hold it for a
  // while - always ready, coin toss, a fixed one-in-five hole, or mostly stalled
  always @(negedge clk_i) begin
    if (rx_span == 0) begin
      rx_mode = $urandom_range(0, 3);
      rx_span = $urandom_range(20, 200);
    end else begin
      rx_span--;
    end
    rx_phase++;
    case (rx_mode)
      0:       m_axis_tready = 1'b1;
      1:       m_axis_tready = ($urandom_range(0, 1) == 1);
      2:       m_axis_tready = ((rx_phase % 5) != 0);
      default: m_axis_tready = ($urandom_range(0, 7) == 0);
    endcase
  end

  // one input transaction; the sender runs in bursts and lowers tvalid only
  // for the gaps between them, so tvalid never drops and rises in one step
  task automatic send(input cmd_e cmd, input logic [IN_BITS-1:0] smp);
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) != 0) begin
        s_axis_tvalid = 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk_i);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
    end
    s_axis_tuser  = cmd;
    s_axis_tdata  = smp;
    s_axis_tvalid = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
    burst_left--;
  endtask

  // wait until every predicted result has been taken, plus a margin for the
  // last line store write-back
  task automatic settle();
    s_axis_tvalid = 1'b0;
    while (outstanding != 0) @(negedge clk_i);
    repeat (16) @(negedge clk_i);
  endtask

  // write both frame registers while the unit is idle
  task automatic set_frame(input logic [CFG_DATA_BITS-1:0] w_raw,
                           input logic [CFG_DATA_BITS-1:0] h_raw);
    settle();
    cfg_index_i = REG_FRAME_WIDTH;
    cfg_data_i  = w_raw;
    cfg_valid_i = 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_index_i = REG_FRAME_HEIGHT;
    cfg_data_i  = h_raw;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
    // width register keeps 11 bits, both clamp to the supported range
    cur_w = 32'(w_raw[CFG_W_BITS-1:0]);
    if (cur_w == 0) cur_w = 1;
    if (cur_w > MAX_WIDTH_DEF) cur_w = MAX_WIDTH_DEF;
    cur_h = 32'(h_raw);
    if (cur_h == 0) cur_h = 1;
    if (cur_h > MAX_HEIGHT) cur_h = MAX_HEIGHT;
  endtask

  // mixes full-range values, clusters round a base (small and zero
  // differences), the signed extremes and small signed values
  function automatic logic [IN_BITS-1:0] pick_sample();
    case ($urandom_range(0, 7))
      0, 1:    return $urandom;
      2, 3, 4: return sample_base + $urandom_range(0, 15);
      5: begin
        case ($urandom_range(0, 3))
          0:       return 32'h7FFF_FFFF;
          1:       return 32'h8000_0000;
          2:       return 32'h0000_0000;
          default: return 32'hFFFF_FFFF;
        endcase
      end
      6:       return 32'($urandom_range(0, 63)) - 32'd32;
      default: return sample_base;
    endcase
  endfunction

  // a whole frame: its pixels, with the odd stray flush that gets swallowed,
  // then the drain items, some of them pixels whose data is dropped
  task automatic run_frame(input int unsigned noise_pct);
    int unsigned total, lag;
    total = cur_w * cur_h;
    lag   = RADIUS_DEF * cur_w + RADIUS_DEF;
    for (int unsigned i = 0; i < total; i++) begin
      if ($urandom_range(0, 99) < noise_pct) send(CMD_FLUSH, $urandom);
      send(CMD_PIXEL, pick_sample());
    end
    for (int unsigned i = 0; i < lag; i++) begin
      if ($urandom_range(0, 99) < 30) send(CMD_PIXEL, $urandom);
      else send(CMD_FLUSH, $urandom);
    end
    items_done += total + lag;
  endtask

  initial begin
    logic [CFG_DATA_BITS-1:0] w_raw, h_raw;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // lone pixel: zero registers act as one, no neighbour so the flag is set
    set_frame('0, '0);
    send(CMD_FLUSH, 32'h1234_5678);
    send(CMD_PIXEL, 32'h7FFF_FFFF);
    send(CMD_FLUSH, '0);
    send(CMD_PIXEL, 32'h0000_0000);
    send(CMD_FLUSH, '0);
    send(CMD_PIXEL, 32'hFFFF_FFFF);
    send(CMD_FLUSH, '0);
    send(CMD_FLUSH, '0);

    // two pixels at opposite extremes: full-scale difference, still found
    set_frame(13'd2, 13'd1);
    send(CMD_PIXEL, 32'h7FFF_FFFF);
    send(CMD_PIXEL, 32'h8000_0000);
    for (int i = 0; i < 9; i++) begin
      if (i % 3 == 1) send(CMD_PIXEL, (i % 2 == 0) ? 32'h0 : 32'hFFFF_FFFF);
      else send(CMD_FLUSH, 32'hFFFF_FFFF);
    end

    // random frame sizes; the width register sometimes carries unused high bits
    while (items_done < 1600) begin
      case ($urandom_range(0, 9))
        0:       w_raw = '0;
        1:       w_raw = CFG_DATA_BITS'($urandom_range(13, 40));
        default: w_raw = CFG_DATA_BITS'($urandom_range(1, 12));
      endcase
      if ($urandom_range(0, 3) == 0) begin
        w_raw[CFG_DATA_BITS-1:CFG_W_BITS] = (CFG_DATA_BITS-CFG_W_BITS)'($urandom_range(1, 3));
      end
      h_raw = ($urandom_range(0, 9) == 0) ? '0 : CFG_DATA_BITS'($urandom_range(1, 10));
      set_frame(w_raw, h_raw);
      repeat ($urandom_range(1, 3)) begin
        sample_base = $urandom;
        run_frame($urandom_range(0, 15));
      end
    end

    settle();
    repeat (32) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("window_min_abs_difference_unit regression: pass");
    end else begin
      $display("window_min_abs_difference_unit regression: fail");
    end
    $finish;
  end

  // watchdog, several times the slowest legal run
  initial begin
    #10_000_000;
    $display("window_min_abs_difference_unit regression: fail");
    $finish;
  end

endmodule
